/* hw/rtl/salt_pkg.sv */
package salt_pkg;

  // fixed field widths
  localparam int ADDR_W        = 64;
  localparam int KIND_W        = 2;
  localparam int TOTAL_W       = 32;
  localparam int INDEX_BITS_W  = 3;
  localparam int OFFSET_BITS_W = 6;
  localparam int WAYS_W        = 4;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 6;

  // default geometry
  localparam int DEF_SET_COUNT = 64;
  localparam int DEF_WAY_COUNT = 8;

  // access kinds
  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STORE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_BITS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_BITS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

  // configuration reset values
  localparam logic [INDEX_BITS_W-1:0]  RST_INDEX_BITS  = 3'd4;
  localparam logic [OFFSET_BITS_W-1:0] RST_OFFSET_BITS = 6'd4;
  localparam logic [WAYS_W-1:0]        RST_WAYS_IN_USE = 4'd1;

  // controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_SECOND
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear;    // zero one set row of the memory
    logic capture;  // take the request and read its set row
    logic commit;   // resolve the access and write the row back
    logic second;   // store half of a modify
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;  // clearing pass is at its final row
    logic in_none;     // incoming request has the unused kind
    logic cur_modify;  // request held is a modify
    logic out_free;    // result register can take a result this cycle
  } dp_stat_t;

endpackage

/* hw/rtl/salt_req_if.sv */
interface salt_req_if
  import salt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output kind, output address, input ready);
  modport sink (input valid, input kind, input address, output ready);
endinterface

/* hw/rtl/salt_res_if.sv */
interface salt_res_if
  import salt_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               hit;
  logic               miss;
  logic               evicted;
  logic [TOTAL_W-1:0] hits_so_far;
  logic [TOTAL_W-1:0] misses_so_far;
  logic [TOTAL_W-1:0] evictions_so_far;
  logic               last;

  modport source (
    output valid, output hit, output miss, output evicted, output hits_so_far,
    output misses_so_far, output evictions_so_far, output last, input ready
  );
  modport sink (
    input valid, input hit, input miss, input evicted, input hits_so_far,
    input misses_so_far, input evictions_so_far, input last, output ready
  );
endinterface

/* hw/rtl/salt_cfg_if.sv */
interface salt_cfg_if
  import salt_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/salt_ctrl.sv */
module salt_ctrl
  import salt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_stat_t   stat,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = in_valid && in_ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && !stat.in_none) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (stat.out_free) state_next = stat.cur_modify ? ST_SECOND : ST_IDLE;
      end
      ST_SECOND: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
      end
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_LOOKUP: begin
        cmd.commit = stat.out_free;
      end
      ST_SECOND: begin
        cmd.second = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

/* hw/rtl/salt_datapath.sv */
module salt_datapath
  import salt_pkg::*;
#(
  parameter int SET_COUNT = DEF_SET_COUNT,
  parameter int WAY_COUNT = DEF_WAY_COUNT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [KIND_W-1:0] kind,
  input  logic [ADDR_W-1:0] address,
  input  ctrl_cmd_t         cmd,
  output dp_stat_t          stat,
  salt_cfg_if.sink          cfg,
  salt_res_if.source        res
);

  localparam int SW        = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int RW        = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int MAXIB     = $clog2(SET_COUNT + 1) - 1;
  localparam int SHIFT_W   = 7;
  localparam logic [RW-1:0] RANK_MAX = RW'(WAY_COUNT - 1);

  // configuration registers
  logic [INDEX_BITS_W-1:0]  index_bits;
  logic [OFFSET_BITS_W-1:0] offset_bits;
  logic [WAYS_W-1:0]        ways_in_use;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      index_bits  <= RST_INDEX_BITS;
      offset_bits <= RST_OFFSET_BITS;
      ways_in_use <= RST_WAYS_IN_USE;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_INDEX_BITS:  index_bits  <= cfg.data[INDEX_BITS_W-1:0];
        CFG_OFFSET_BITS: offset_bits <= cfg.data[OFFSET_BITS_W-1:0];
        CFG_WAYS_IN_USE: ways_in_use <= cfg.data[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // effective split and way count
  logic [INDEX_BITS_W-1:0] ib_eff;
  logic [WAYS_W-1:0]       ways_eff;
  logic [WAY_COUNT-1:0]    in_use;
  logic [ADDR_W-1:0]       idx_mask;
  logic [ADDR_W-1:0]       idx_field;
  logic [SHIFT_W-1:0]      tag_shift;
  logic [SW-1:0]           set_in;

  always_comb begin
    ib_eff = (32'(index_bits) > MAXIB) ? INDEX_BITS_W'(MAXIB) : index_bits;
    if (ways_in_use == '0) begin
      ways_eff = WAYS_W'(1);
    end else if (32'(ways_in_use) > WAY_COUNT) begin
      ways_eff = WAYS_W'(WAY_COUNT);
    end else begin
      ways_eff = ways_in_use;
    end
    for (int w = 0; w < WAY_COUNT; w++) begin
      in_use[w] = (32'(w) < 32'(ways_eff));
    end
    idx_mask  = (ADDR_W'(1) << ib_eff) - ADDR_W'(1);
    idx_field = (address >> offset_bits) & idx_mask;
    set_in    = idx_field[SW-1:0];
    tag_shift = SHIFT_W'(ib_eff) + SHIFT_W'(offset_bits);
  end

  // request hold
  logic [SW-1:0]     set_r;
  logic [ADDR_W-1:0] tag_r;
  logic              modify_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      set_r    <= set_in;
      tag_r    <= address >> tag_shift;
      modify_r <= (kind == KIND_MODIFY);
    end
  end

  // set row memory: valid bits, recency ranks and tags of all ways
  logic [WAY_COUNT-1:0]             mem_valid [SET_COUNT];
  logic [WAY_COUNT-1:0][RW-1:0]     mem_rank  [SET_COUNT];
  logic [WAY_COUNT-1:0][ADDR_W-1:0] mem_tag   [SET_COUNT];
  logic [WAY_COUNT-1:0]             rd_valid;
  logic [WAY_COUNT-1:0][RW-1:0]     rd_rank;
  logic [WAY_COUNT-1:0][ADDR_W-1:0] rd_tag;
  logic [WAY_COUNT-1:0]             new_valid;
  logic [WAY_COUNT-1:0][RW-1:0]     new_rank;
  logic [WAY_COUNT-1:0][ADDR_W-1:0] new_tag;
  logic [SW-1:0]                    clear_ptr;
  logic [SW-1:0]                    wr_addr;

  assign wr_addr = cmd.clear ? clear_ptr : set_r;

  always_ff @(posedge clk) begin
    if (cmd.clear || cmd.commit) begin
      mem_valid[wr_addr] <= cmd.clear ? '0 : new_valid;
      mem_rank[wr_addr]  <= cmd.clear ? '0 : new_rank;
    end
    if (cmd.commit) begin
      mem_tag[set_r] <= new_tag;
    end
    if (cmd.capture) begin
      rd_valid <= mem_valid[set_in];
      rd_rank  <= mem_rank[set_in];
      rd_tag   <= mem_tag[set_in];
    end
  end

  // clearing pass pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_ptr <= '0;
    end else if (cmd.clear) begin
      clear_ptr <= clear_ptr + SW'(1);
    end
  end

  // lookup, replacement choice and rank update
  logic [WAY_COUNT-1:0] match;
  logic [WAY_COUNT-1:0] free;
  logic [WAY_COUNT-1:0] is_max;
  logic                 hit;
  logic                 has_free;
  logic                 evict;
  logic [RW-1:0]        hit_way;
  logic [RW-1:0]        free_way;
  logic [RW-1:0]        victim;
  logic [RW-1:0]        tgt_way;
  logic [RW-1:0]        below;
  logic                 age_all;

  always_comb begin
    for (int w = 0; w < WAY_COUNT; w++) begin
      match[w]  = in_use[w] && rd_valid[w] && (rd_tag[w] == tag_r);
      free[w]   = in_use[w] && !rd_valid[w];
      is_max[w] = in_use[w];
      for (int v = 0; v < WAY_COUNT; v++) begin
        if (in_use[v] && (rd_rank[v] > rd_rank[w])) is_max[w] = 1'b0;
      end
    end
    hit      = |match;
    has_free = |free;
    evict    = !hit && !has_free;
    hit_way  = '0;
    free_way = '0;
    victim   = '0;
    // lowest-numbered way wins each choice
    for (int w = WAY_COUNT - 1; w >= 0; w--) begin
      if (match[w])  hit_way  = RW'(w);
      if (free[w])   free_way = RW'(w);
      if (is_max[w]) victim   = RW'(w);
    end
    priority if (hit) begin
      tgt_way = hit_way;
    end else if (has_free) begin
      tgt_way = free_way;
    end else begin
      tgt_way = victim;
    end
    age_all = !hit && has_free;
    below   = rd_rank[tgt_way];
    new_valid = rd_valid;
    new_rank  = rd_rank;
    new_tag   = rd_tag;
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (RW'(w) == tgt_way) begin
        new_rank[w] = '0;
        if (!hit) begin
          new_valid[w] = 1'b1;
          new_tag[w]   = tag_r;
        end
      end else if (in_use[w] && rd_valid[w] && (age_all || (rd_rank[w] < below))
                   && (rd_rank[w] < RANK_MAX)) begin
        new_rank[w] = rd_rank[w] + RW'(1);
      end
    end
  end

  // running totals
  logic [TOTAL_W-1:0] hit_total;
  logic [TOTAL_W-1:0] miss_total;
  logic [TOTAL_W-1:0] eviction_total;
  logic [TOTAL_W-1:0] hit_total_next;
  logic [TOTAL_W-1:0] miss_total_next;
  logic [TOTAL_W-1:0] eviction_total_next;
  logic               r_hit;

  // store half of a modify always hits the line just touched, ranks unchanged
  assign r_hit               = cmd.second || hit;
  assign hit_total_next      = hit_total + TOTAL_W'(r_hit);
  assign miss_total_next     = miss_total + TOTAL_W'(!cmd.second && !hit);
  assign eviction_total_next = eviction_total + TOTAL_W'(!cmd.second && evict);

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_total      <= '0;
      miss_total     <= '0;
      eviction_total <= '0;
    end else if (cmd.commit || cmd.second) begin
      hit_total      <= hit_total_next;
      miss_total     <= miss_total_next;
      eviction_total <= eviction_total_next;
    end
  end

  // result register
  logic out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit || cmd.second) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit || cmd.second) begin
      res.hit              <= r_hit;
      res.miss             <= !cmd.second && !hit;
      res.evicted          <= !cmd.second && evict;
      res.hits_so_far      <= hit_total_next;
      res.misses_so_far    <= miss_total_next;
      res.evictions_so_far <= eviction_total_next;
      res.last             <= cmd.second || !modify_r;
    end
  end

  assign res.valid = out_valid;

  // status
  assign stat.clear_last = (clear_ptr == SW'(SET_COUNT - 1));
  assign stat.in_none    = (kind != KIND_LOAD) && (kind != KIND_STORE)
                           && (kind != KIND_MODIFY);
  assign stat.cur_modify = modify_r;
  assign stat.out_free   = !out_valid || res.ready;

endmodule

/* hw/rtl/set_assoc_cache_lru_tracker.sv */
// Tag-only set-associative cache tracker with LRU replacement. Each request
// is a load, store or modify to a 64-bit byte address; loads and stores give
// one result, a modify gives two (load then store), the unused kind gives
// none. Each set row (valid bits, ranks, tags of all ways) sits in one memory
// word: a load or store reads the row, then does lookup and write-back, and a
// modify then adds its store half; each result step waits for the one result
// register. A new request is taken while a result still waits. After reset
// a clearing pass over all SET_COUNT rows zeroes the valid bits and ranks, during
// which no request is taken; configuration writes are taken at any time and
// must only be issued while the block is idle.
module set_assoc_cache_lru_tracker
  import salt_pkg::*;
#(
  parameter int SET_COUNT = DEF_SET_COUNT,
  parameter int WAY_COUNT = DEF_WAY_COUNT
) (
  input  logic       clk,
  input  logic       rst,
  salt_req_if.sink   req,
  salt_res_if.source res,
  salt_cfg_if.sink   cfg
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencer
  salt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // lookup datapath with set memory and totals
  salt_datapath #(
    .SET_COUNT (SET_COUNT),
    .WAY_COUNT (WAY_COUNT)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .kind    (req.kind),
    .address (req.address),
    .cmd     (cmd),
    .stat    (stat),
    .cfg     (cfg),
    .res     (res)
  );

endmodule

/* tb/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import salt_pkg::*;

  localparam int SETS          = DEF_SET_COUNT;
  localparam int WAYS          = DEF_WAY_COUNT;
  localparam int MAX_IB        = $clog2(SETS + 1) - 1;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 218;
  localparam int POOL_SIZE     = 12;
  localparam int SETTLE        = 10;
  localparam int LONG_HOLD     = 400;
  localparam int IDLE_LIMIT    = 2000;
  localparam int N_PLAN        = 29;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [KIND_W-1:0] ACCESS_KINDS [3] = '{KIND_LOAD, KIND_STORE, KIND_MODIFY};

  // split and way settings of the first random phases, the rest are drawn
  localparam int PH_IB   [4] = '{4, 0, 7, 6};
  localparam int PH_OB   [4] = '{6, 0, 63, 57};
  localparam int PH_WAYS [4] = '{4, 8, 15, 1};

  typedef struct packed {
    bit        hit;
    bit        miss;
    bit        evicted;
    bit [31:0] hits;
    bit [31:0] misses;
    bit [31:0] evictions;
    bit        last;
  } access_outcome_t;

  typedef struct {
    bit                     is_cfg;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    logic [KIND_W-1:0]      kind;
    logic [ADDR_W-1:0]      addr;
    bit                     typed;
    bit                     t_hit;
    bit                     t_miss;
    bit                     t_ev;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  salt_req_if req_ch ();
  salt_res_if res_ch ();
  salt_cfg_if cfg_ch ();

  set_assoc_cache_lru_tracker DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the tag store and its settings
  bit                     ln_valid [SETS][WAYS];
  bit [ADDR_W-1:0]        ln_tag   [SETS][WAYS];
  bit [2:0]               ln_rank  [SETS][WAYS];
  bit [TOTAL_W-1:0]       tot_hits, tot_misses, tot_evicts;
  bit [INDEX_BITS_W-1:0]  sh_index_bits  = RST_INDEX_BITS;
  bit [OFFSET_BITS_W-1:0] sh_offset_bits = RST_OFFSET_BITS;
  bit [WAYS_W-1:0]        sh_ways        = RST_WAYS_IN_USE;

  access_outcome_t access_outcomes [$];
  logic [ADDR_W-1:0] block_pool [POOL_SIZE];

  int  fail_count     = 0;
  int  requests_done  = 0;
  int  directed_count = 0;
  int  results_seen   = 0;
  bit  long_hold      = 1'b0;
  bit  rx_calm        = 1'b0;

  // directed requests and register writes, flags typed in where obvious
  //  cfg reg              value  kind         address                typed hit miss ev
  plan_row_t plan [N_PLAN] = '{
    '{0, CFG_INDEX_BITS,  6'd0,  KIND_LOAD,   64'h0,                 1, 0, 1, 0},
    '{0, CFG_INDEX_BITS,  6'd0,  KIND_LOAD,   64'h0,                 1, 1, 0, 0},
    '{0, CFG_INDEX_BITS,  6'd0,  KIND_STORE,  64'hF,                 1, 1, 0, 0},
    '{0, CFG_INDEX_BITS,  6'd0,  KIND_UNUSED, 64'h0,                 0, 0, 0, 0},
    '{0, CFG_INDEX_BITS,  6'd0,  KIND_MODIFY, 64'h10,                1, 0, 1, 0},
    '{0, CFG_INDEX_BITS,  6'd0,  KIND_LOAD,   64'h100,               1, 0, 1, 1},
    '{0, CFG_INDEX_BITS,  6'd0,  KIND_LOAD,   64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 1, 0},
    '{0, CFG_INDEX_BITS,  6'd0,  KIND_LOAD,   64'h8000_0000_0000_0000, 1, 0, 1, 1},
    '{1, CFG_WAYS_IN_USE, 6'd8,  KIND_LOAD,   64'h0,                 0, 0, 0, 0},
    '{0, CFG_INDEX_BITS,  6'd0,  KIND_LOAD,   64'h200,               1, 0, 1, 0},
    '{1, CFG_WAYS_IN_USE, 6'd15, KIND_LOAD,   64'h0,                 0, 0, 0, 0},
    '{0, CFG_INDEX_BITS,  6'd0,  KIND_LOAD,   64'h300,               1, 0, 1, 0},
    '{0, CFG_INDEX_BITS,  6'd0,  KIND_MODIFY, 64'h100,               0, 0, 0, 0},
    '{1, CFG_INDEX_BITS,  6'd7,  KIND_LOAD,   64'h0,                 0, 0, 0, 0},
    '{1, CFG_OFFSET_BITS, 6'd63, KIND_LOAD,   64'h0,                 0, 0, 0, 0},
    '{0, CFG_INDEX_BITS,  6'd0,  KIND_LOAD,   64'h8000_0000_0000_0000, 0, 0, 0, 0},
    '{0, CFG_INDEX_BITS,  6'd0,  KIND_LOAD,   64'h0,                 0, 0, 0, 0},
    '{1, CFG_WAYS_IN_USE, 6'd0,  KIND_LOAD,   64'h0,                 0, 0, 0, 0},
    '{1, CFG_INDEX_BITS,  6'd0,  KIND_LOAD,   64'h0,                 0, 0, 0, 0},
    '{1, CFG_OFFSET_BITS, 6'd0,  KIND_LOAD,   64'h0,                 0, 0, 0, 0},
    '{0, CFG_INDEX_BITS,  6'd0,  KIND_LOAD,   64'hDEAD_BEEF_0000_0001, 0, 0, 0, 0},
    '{0, CFG_INDEX_BITS,  6'd0,  KIND_STORE,  64'h1234,              0, 0, 0, 0},
    '{1, CFG_INDEX_BITS,  6'd6,  KIND_LOAD,   64'h0,                 0, 0, 0, 0},
    '{1, CFG_OFFSET_BITS, 6'd57, KIND_LOAD,   64'h0,                 0, 0, 0, 0},
    '{0, CFG_INDEX_BITS,  6'd0,  KIND_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0},
    '{0, CFG_INDEX_BITS,  6'd0,  KIND_LOAD,   64'hFE00_0000_0000_0000, 0, 0, 0, 0},
    '{0, CFG_INDEX_BITS,  6'd0,  KIND_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0},
    '{1, CFG_WAYS_IN_USE, 6'd8,  KIND_LOAD,   64'h0,                 0, 0, 0, 0},
    '{0, CFG_INDEX_BITS,  6'd0,  KIND_STORE,  64'h0200_0000_0000_0000, 0, 0, 0, 0}
  };

  // lines in use younger than the bound move one rank older
  function automatic void age_set(int s, int nways, int skip, int bound);
    for (int w = 0; w < nways; w++) begin
      if (w != skip && ln_valid[s][w] && ln_rank[s][w] < bound && ln_rank[s][w] < WAYS - 1)
        ln_rank[s][w]++;
    end
  endfunction

  function automatic logic [ADDR_W-1:0] low_mask(int n);
    return (n >= ADDR_W) ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  // one lookup and fill of the tag store
  function automatic access_outcome_t resolve_access(logic [ADDR_W-1:0] addr, bit is_last);
    access_outcome_t r;
    int ib, ob, nways, s, fill, victim;
    bit [ADDR_W-1:0] tag;
    bit found;
    ib = (sh_index_bits > MAX_IB) ? MAX_IB : int'(sh_index_bits);
    ob = sh_offset_bits;
    nways = (sh_ways == 0) ? 1 : ((sh_ways > WAYS) ? WAYS : int'(sh_ways));
    s = int'((addr >> ob) & low_mask(ib));
    tag = (ib + ob >= ADDR_W) ? '0 : (addr >> (ib + ob));
    r = '0;
    found = 1'b0;
    for (int w = 0; w < nways && !found; w++) begin
      if (ln_valid[s][w] && ln_tag[s][w] == tag) begin
        age_set(s, nways, w, ln_rank[s][w]);
        ln_rank[s][w] = '0;
        found = 1'b1;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      tot_hits++;
    end else begin
      // lowest invalid way first, else the oldest line
      fill = nways;
      for (int w = nways - 1; w >= 0; w--)
        if (!ln_valid[s][w]) fill = w;
      if (fill < nways) begin
        age_set(s, nways, fill, 256);
      end else begin
        victim = 0;
        for (int w = 1; w < nways; w++)
          if (ln_rank[s][w] > ln_rank[s][victim]) victim = w;
        fill = victim;
        r.evicted = 1'b1;
        tot_evicts++;
        age_set(s, nways, fill, ln_rank[s][fill]);
      end
      ln_valid[s][fill] = 1'b1;
      ln_tag[s][fill]   = tag;
      ln_rank[s][fill]  = '0;
      r.miss = 1'b1;
      tot_misses++;
    end
    r.hits      = tot_hits;
    r.misses    = tot_misses;
    r.evictions = tot_evicts;
    r.last      = is_last;
    return r;
  endfunction

  // queue the results one request causes
  function automatic void predict_request(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                                          bit typed, bit t_hit, bit t_miss, bit t_ev);
    access_outcome_t first;
    if (kind == KIND_UNUSED) return;
    first = resolve_access(addr, kind != KIND_MODIFY);
    if (typed) begin
      first.hit     = t_hit;
      first.miss    = t_miss;
      first.evicted = t_ev;
    end
    access_outcomes.push_back(first);
    if (kind == KIND_MODIFY)
      access_outcomes.push_back(resolve_access(addr, 1'b1));
  endfunction

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {$urandom(), $urandom()};
  endfunction

  // fresh block address, set index kept to a few sets so lines compete
  function automatic logic [ADDR_W-1:0] block_base();
    logic [ADDR_W-1:0] a, fmask;
    int ib;
    ib = (sh_index_bits > MAX_IB) ? MAX_IB : int'(sh_index_bits);
    a = rand_addr();
    fmask = low_mask(ib) << sh_offset_bits;
    a = (a & ~fmask) | ((64'($urandom_range(0, 3)) << sh_offset_bits) & fmask);
    return a;
  endfunction

  function automatic void cmp(string field, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", field, exp_v, got_v);
      fail_count++;
    end
  endfunction

  task automatic offer(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                       bit typed = 1'b0, bit t_hit = 1'b0, bit t_miss = 1'b0, bit t_ev = 1'b0);
    req_ch.valid   <= 1'b1;
    req_ch.kind    <= kind;
    req_ch.address <= addr;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    predict_request(kind, addr, typed, t_hit, t_miss, t_ev);
    if (kind != KIND_UNUSED) requests_done++;
  endtask

  task automatic tx_pause(int n);
    if (n > 0) begin
      req_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // stop offering until every result is back and the pipeline is quiet
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (access_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val, bit keep);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    if (!keep) cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_INDEX_BITS:  sh_index_bits  = val[INDEX_BITS_W-1:0];
      CFG_OFFSET_BITS: sh_offset_bits = val[OFFSET_BITS_W-1:0];
      CFG_WAYS_IN_USE: sh_ways        = val[WAYS_W-1:0];
      default: ;
    endcase
  endtask

  // result side: random back-pressure, one long hold-off on demand
  initial begin : result_sink
    int gap;
    res_ch.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
        res_ch.ready <= 1'b1;
      end else begin
        gap = pick_gap(rx_calm);
        if (gap == 0) begin
          res_ch.ready <= 1'b1;
        end else begin
          res_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
          res_ch.ready <= 1'b1;
        end
      end
    end
  end

  // compare each result with the oldest outstanding one
  always @(posedge clk) begin : result_check
    access_outcome_t e;
    if (rst === 1'b0 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (access_outcomes.size() == 0) begin
        $error("result arrived with none outstanding");
        fail_count++;
      end else begin
        e = access_outcomes.pop_front();
        cmp("hit", e.hit, res_ch.hit);
        cmp("miss", e.miss, res_ch.miss);
        cmp("evicted", e.evicted, res_ch.evicted);
        cmp("hits_so_far", e.hits, res_ch.hits_so_far);
        cmp("misses_so_far", e.misses, res_ch.misses_so_far);
        cmp("evictions_so_far", e.evictions, res_ch.evictions_so_far);
        cmp("last", e.last, res_ch.last);
        results_seen++;
      end
    end
  end

  // no handshake on any channel for too long ends the run
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) ||
          (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
        idle = 0;
      else
        idle++;
    end
    $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
             IDLE_LIMIT, access_outcomes.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] addr, lm;
    int n, r, slot, ib, ob, nw;
    bit calm;
    req_ch.valid   = 1'b0;
    req_ch.kind    = KIND_LOAD;
    req_ch.address = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = CFG_INDEX_BITS;
    cfg_ch.data    = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed part
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        write_reg(plan[i].reg_idx, plan[i].reg_val, 1'b0);
      end else begin
        offer(plan[i].kind, plan[i].addr, plan[i].typed,
              plan[i].t_hit, plan[i].t_miss, plan[i].t_ev);
        tx_pause(pick_gap(1'b0));
      end
    end
    directed_count = requests_done;

    // random phases, each under its own split and way count
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      if (p < 4) begin
        ib = PH_IB[p];
        ob = PH_OB[p];
        nw = PH_WAYS[p];
      end else begin
        ib = $urandom_range(0, 7);
        ob = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 12);
        nw = $urandom_range(0, 15);
      end
      write_reg(CFG_INDEX_BITS, CFG_DATA_W'(ib), 1'b1);
      write_reg(CFG_OFFSET_BITS, CFG_DATA_W'(ob), 1'b1);
      write_reg(CFG_WAYS_IN_USE, CFG_DATA_W'(nw), 1'b0);
      calm = (p == 5);
      rx_calm = calm;
      foreach (block_pool[j]) block_pool[j] = block_base();

      n = 0;
      while (n < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          kind = KIND_UNUSED;
          addr = rand_addr();
        end else begin
          kind = ACCESS_KINDS[$urandom_range(0, 2)];
          if (r < 15) begin
            addr = rand_addr();
          end else begin
            // mostly reuse a known block, now and then swap one out
            slot = $urandom_range(0, POOL_SIZE - 1);
            if (r < 25) block_pool[slot] = block_base();
            lm = low_mask(sh_offset_bits);
            addr = (block_pool[slot] & ~lm) | (rand_addr() & lm);
          end
        end
        offer(kind, addr);
        if (kind != KIND_UNUSED) begin
          n++;
          if (p == 1 && n == 40) long_hold = 1'b1;
          if (p == 2 && n == 100) drain();
        end
        tx_pause(pick_gap(calm));
      end
    end

    drain();
    $display("Checked %0d results of %0d requests (%0d directed): %0d hit, %0d miss, %0d evict",
             results_seen, requests_done, directed_count, tot_hits, tot_misses, tot_evicts);
    $display("%0d random phases over varied index/offset/way settings, incl. long result stall",
             RANDOM_PHASES);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
